// ===== hw/rtl/cdz_pkg.sv =====
// Shared constants for the circular dead-zone stick scaler.
`timescale 1ns / 1ps

package cdz_pkg;

   localparam int RAW_W      = 16;
   localparam int PAD_W      = 8;
   localparam int DZ_W       = 15;
   localparam int GAIN_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN = 1'b1;

   localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 15'd6554;
   localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = 7'd100;

   localparam logic [PAD_W-1:0] PAD_CENTER = 8'd128;
   localparam logic [PAD_W-1:0] PAD_MAX    = 8'd255;
   localparam logic [PAD_W-1:0] PAD_MIN    = 8'd0;

endpackage

// ===== hw/rtl/circular_deadzone_stick_scaler.sv =====
// Top level of the circular dead-zone stick scaler.
//
// The req channel takes one word per cycle, unless stalled, holding a signed
// stick position (raw_x, raw_y). The rsp channel returns one word per request
// holding two centred bytes (pad_x, pad_y), saturated to 0..255 and in
// request order. Each axis is scaled to a fraction, the vector magnitude goes
// through a square root pipeline, and the rescaled magnitude and the unit
// direction come from three parallel divider pipelines before two multiply
// stages. The square root and divider pipelines resolve one bit per stage.
// Throughput is one word per cycle when the receiver does not stall.
// The csr port writes the dead zone and the output gain; it must be written
// only while no word is in flight, which the block itself does not enforce.
// Reset is synchronous and empties the pipeline; the registers return to a
// dead zone of 6554 and a gain of 100.
// When the receiver stalls, the whole pipeline holds and req_tready drops,
// so no word is lost or repeated.
`timescale 1ns / 1ps

module circular_deadzone_stick_scaler #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_x [15:0], raw_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pad_x [7:0], pad_y [15:8]
   input  logic                             csr_we,
   input  logic [cdz_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cdz_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RW   = FRAC_BITS + 1;
   localparam int XW   = 16 + FRAC_BITS;
   localparam int R0W  = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 1;
   localparam int SQW  = 2 * FRAC_BITS + 2;
   localparam int REMW = RW + 3;
   localparam int NW   = 2 * FRAC_BITS + 1;
   localparam int GW   = RW + cdz_pkg::GAIN_W;
   localparam int QW   = FRAC_BITS + 2;
   localparam int PW   = GW + QW;
   localparam int LAT  = 2 * RW + 6;
   localparam int DZW  = cdz_pkg::DZ_W + FRAC_BITS;

   typedef struct packed {
      logic          nx;
      logic          ny;
      logic [RW-1:0] ax;
      logic [RW-1:0] ay;
   } axis_type;

   typedef struct packed {
      logic inner;
      logic nx;
      logic ny;
   } flag_type;

   logic advance;
   logic [LAT-1:0] vld_ff;

   logic [cdz_pkg::DZ_W-1:0]   dead_zone_ff;
   logic [cdz_pkg::GAIN_W-1:0] output_gain_ff;

   axis_type      s1_side_ff;
   axis_type      s2_side_ff;
   logic [SQW-1:0] sumsq_ff;

   logic [REMW-1:0] sq_rem_ff  [RW];
   logic [RW-1:0]   sq_root_ff [RW];
   logic [SQW-1:0]  sq_rad_ff  [RW];
   axis_type        sq_side_ff [RW];

   logic [DZW-1:0] dz_wide;
   logic [RW-1:0]  dz;
   logic [RW-1:0]  m_cur;
   logic           inner_in;

   logic [NW-1:0] pre_num_s_ff;
   logic [RW-1:0] pre_den_s_ff;
   logic [NW-1:0] pre_num_x_ff;
   logic [NW-1:0] pre_num_y_ff;
   logic [RW-1:0] pre_m_ff;
   flag_type      pre_flag_ff;

   flag_type      dv_flag_ff [RW];
   logic [RW-1:0] s_quot;
   logic [RW-1:0] dx_quot;
   logic [RW-1:0] dy_quot;

   logic [2*RW-1:0] ss_prod;
   logic [QW-1:0]   m1_q_ff;
   logic [GW-1:0]   m1_dgx_ff;
   logic [GW-1:0]   m1_dgy_ff;
   flag_type        m1_flag_ff;

   logic [PW-1:0] m2_px_ff;
   logic [PW-1:0] m2_py_ff;
   flag_type      m2_flag_ff;

   logic [15:0] rsp_tdata_ff;

   function automatic logic [RW-1:0] axis_frac(input logic [15:0] v);
      logic [15:0]      a;
      logic [XW-1:0]    x;
      logic [FRAC_BITS-1:0] q0;
      logic [R0W-1:0]   r0;
      logic [R0W-17:0]  q1;
      logic [16:0]      r1;
      a  = {v[14:0] ^ {15{v[15]}}, 1'b1};
      x  = XW'(a) << FRAC_BITS;
      q0 = x[XW-1:16];
      r0 = R0W'(x[15:0]) + R0W'(q0);
      q1 = r0[R0W-1:16];
      r1 = 17'(r0[15:0]) + 17'(q1);
      return RW'(q0) + RW'(q1) + RW'(r1 >= 17'd65535);
   endfunction

   function automatic logic [cdz_pkg::PAD_W-1:0] place(
      input logic [PW-2*FRAC_BITS-1:0] c, input logic neg);
      logic [cdz_pkg::PAD_W-1:0] res;
      if (neg) begin
         res = (c >= (PW-2*FRAC_BITS)'(128)) ? cdz_pkg::PAD_MIN
             : cdz_pkg::PAD_CENTER - c[cdz_pkg::PAD_W-1:0];
      end else begin
         res = (c >= (PW-2*FRAC_BITS)'(127)) ? cdz_pkg::PAD_MAX
             : cdz_pkg::PAD_CENTER + c[cdz_pkg::PAD_W-1:0];
      end
      return res;
   endfunction

   assign advance    = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff   <= cdz_pkg::DEAD_ZONE_RST;
         output_gain_ff <= cdz_pkg::OUTPUT_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            cdz_pkg::CSR_DEAD_ZONE: begin
               dead_zone_ff <= csr_wdata[cdz_pkg::DZ_W-1:0];
            end
            cdz_pkg::CSR_OUTPUT_GAIN: begin
               output_gain_ff <= csr_wdata[cdz_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff.nx <= req_tdata[15];
         s1_side_ff.ny <= req_tdata[31];
         s1_side_ff.ax <= axis_frac(req_tdata[15:0]);
         s1_side_ff.ay <= axis_frac(req_tdata[31:16]);
         s2_side_ff    <= s1_side_ff;
         sumsq_ff      <= SQW'(s1_side_ff.ax * s1_side_ff.ax)
                        + SQW'(s1_side_ff.ay * s1_side_ff.ay);
      end
   end

   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      logic [REMW-1:0] rem_prev;
      logic [RW-1:0]   root_prev;
      logic [SQW-1:0]  rad_prev;
      axis_type        side_prev;
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = sumsq_ff;
         assign side_prev = s2_side_ff;
      end else begin : g_next
         assign rem_prev  = sq_rem_ff[j-1];
         assign root_prev = sq_root_ff[j-1];
         assign rad_prev  = sq_rad_ff[j-1];
         assign side_prev = sq_side_ff[j-1];
      end

      assign rem_sh = {rem_prev[REMW-3:0], rad_prev[SQW-1 -: 2]};
      assign trial  = REMW'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_rad_ff[j]  <= rad_prev << 2;
            sq_side_ff[j] <= side_prev;
            if (rem_sh >= trial) begin
               sq_rem_ff[j]  <= rem_sh - trial;
               sq_root_ff[j] <= {root_prev[RW-2:0], 1'b1};
            end else begin
               sq_rem_ff[j]  <= rem_sh;
               sq_root_ff[j] <= {root_prev[RW-2:0], 1'b0};
            end
         end
      end
   end

   assign dz_wide  = DZW'(dead_zone_ff) << FRAC_BITS;
   assign dz       = RW'(dz_wide >> 16);
   assign m_cur    = sq_root_ff[RW-1];
   assign inner_in = (m_cur <= dz);

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_num_s_ff <= inner_in ? '0 : (NW'(m_cur - dz) << FRAC_BITS);
         pre_den_s_ff <= (RW'(1) << FRAC_BITS) - dz;
         pre_num_x_ff <= NW'(sq_side_ff[RW-1].ax) << FRAC_BITS;
         pre_num_y_ff <= NW'(sq_side_ff[RW-1].ay) << FRAC_BITS;
         pre_m_ff     <= m_cur;
         pre_flag_ff  <= '{inner: inner_in, nx: sq_side_ff[RW-1].nx,
                           ny: sq_side_ff[RW-1].ny};
      end
   end

   cdz_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_s (
      .clock(clock), .advance(advance),
      .numer(pre_num_s_ff), .denom(pre_den_s_ff), .quot(s_quot)
   );

   cdz_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .advance(advance),
      .numer(pre_num_x_ff), .denom(pre_m_ff), .quot(dx_quot)
   );

   cdz_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .advance(advance),
      .numer(pre_num_y_ff), .denom(pre_m_ff), .quot(dy_quot)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_flag_ff[0] <= pre_flag_ff;
         for (int i = 1; i < RW; i++) begin
            dv_flag_ff[i] <= dv_flag_ff[i-1];
         end
      end
   end

   assign ss_prod = s_quot * s_quot;

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_q_ff    <= ss_prod[2*RW-1:FRAC_BITS];
         m1_dgx_ff  <= GW'(dx_quot) * GW'(output_gain_ff);
         m1_dgy_ff  <= GW'(dy_quot) * GW'(output_gain_ff);
         m1_flag_ff <= dv_flag_ff[RW-1];
         m2_px_ff   <= PW'(m1_dgx_ff) * PW'(m1_q_ff);
         m2_py_ff   <= PW'(m1_dgy_ff) * PW'(m1_q_ff);
         m2_flag_ff <= m1_flag_ff;
         if (m2_flag_ff.inner) begin
            rsp_tdata_ff <= {cdz_pkg::PAD_CENTER, cdz_pkg::PAD_CENTER};
         end else begin
            rsp_tdata_ff <= {place(m2_py_ff[PW-1:2*FRAC_BITS], m2_flag_ff.ny),
                             place(m2_px_ff[PW-1:2*FRAC_BITS], m2_flag_ff.nx)};
         end
      end
   end

endmodule

// ===== hw/rtl/cdz_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module cdz_div_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [2*FRAC_BITS:0]   numer,
   input  logic [FRAC_BITS:0]     denom,
   output logic [FRAC_BITS:0]     quot
);

   localparam int QW = FRAC_BITS + 1;
   localparam int NW = 2 * FRAC_BITS + 1;

   logic [NW-1:0] rem_ff [QW];
   logic [QW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [NW-1:0] rem_prev;
      logic [QW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [NW-1:0] dsh;

      if (k == 0) begin : g_first
         assign rem_prev = numer;
         assign den_prev = denom;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign dsh = NW'(den_prev) << (QW - 1 - k);

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k] <= den_prev;
            if (rem_prev >= dsh) begin
               rem_ff[k] <= rem_prev - dsh;
               quo_ff[k] <= {quo_prev[QW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= rem_prev;
               quo_ff[k] <= {quo_prev[QW-2:0], 1'b0};
            end
         end
      end
   end

   assign quot = quo_ff[QW-1];

endmodule

// ===== test/tb_circular_deadzone_stick_scaler.sv =====
// Self-checking testbench for the circular dead-zone stick scaler.
`timescale 1ns / 1ps

module tb_circular_deadzone_stick_scaler;

   localparam int FB = 16;
   localparam int LATENCY = 2 * FB + 8;

   typedef struct packed {
      logic [cdz_pkg::PAD_W-1:0] pad_y;
      logic [cdz_pkg::PAD_W-1:0] pad_x;
   } pad_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [cdz_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cdz_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [cdz_pkg::DZ_W-1:0] dz_reg = cdz_pkg::DEAD_ZONE_RST;
   logic [cdz_pkg::GAIN_W-1:0] gain_reg = cdz_pkg::OUTPUT_GAIN_RST;

   logic [31:0] stick_queue[$];
   pad_pair_type pads_expected[$];
   int errors = 0;
   int n_checked = 0;
   int n_sent = 0;
   int send_gap = 0;
   int hold_off = 0;
   int recv_gap = 0;
   bit long_stall_done = 1'b0;

   circular_deadzone_stick_scaler #(.FRAC_BITS(FB)) uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] center_offset(logic [63:0] c, bit neg);
      if (neg) return (c >= 128) ? cdz_pkg::PAD_MIN : cdz_pkg::PAD_CENTER - c[7:0];
      return (c >= 127) ? cdz_pkg::PAD_MAX : cdz_pkg::PAD_CENTER + c[7:0];
   endfunction

   function automatic pad_pair_type scale_stick(logic [31:0] word);
      logic signed [17:0] tx, ty;
      logic [63:0] ax, ay, m, one, dz, s, q, dx, dy, cx, cy;
      pad_pair_type p;
      tx = 2 * $signed(word[15:0]) + 1;
      ty = 2 * $signed(word[31:16]) + 1;
      ax = ((tx < 0 ? -tx : tx) << FB) / 65535;
      ay = ((ty < 0 ? -ty : ty) << FB) / 65535;
      m = isqrt(ax * ax + ay * ay);
      one = 64'd1 << FB;
      dz = (64'(dz_reg) << FB) >> 16;
      if (m <= dz) begin
         p.pad_x = cdz_pkg::PAD_CENTER;
         p.pad_y = cdz_pkg::PAD_CENTER;
         return p;
      end
      s = ((m - dz) << FB) / (one - dz);
      q = (s * s) >> FB;
      dx = (ax << FB) / m;
      dy = (ay << FB) / m;
      cx = (dx * q * gain_reg) >> (2 * FB);
      cy = (dy * q * gain_reg) >> (2 * FB);
      p.pad_x = center_offset(cx, tx < 0);
      p.pad_y = center_offset(cy, ty < 0);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) n_sent++;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (stick_queue.size() > 0) begin
            req_tdata <= stick_queue[0];
            pads_expected.push_back(scale_stick(stick_queue.pop_front()));
            req_tvalid <= 1'b1;
            send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && !long_stall_done && n_sent > 120) begin
         hold_off <= hold_off + 1;
         if (hold_off >= 149) long_stall_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pad_pair_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pads_expected.size() == 0) begin
            $error("unexpected word pad_x=%0d pad_y=%0d", got.pad_x, got.pad_y);
            errors++;
         end else begin
            want = pads_expected.pop_front();
            if (got.pad_x !== want.pad_x) begin
               $error("pad_x expected %0d got %0d", want.pad_x, got.pad_x);
               errors++;
            end
            if (got.pad_y !== want.pad_y) begin
               $error("pad_y expected %0d got %0d", want.pad_y, got.pad_y);
               errors++;
            end
         end
         n_checked++;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!long_stall_done && n_sent > 120) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && !rsp_tready) recv_gap = 0;
         else if ($urandom_range(0, 3) == 0) recv_gap = $urandom_range(0, 15);
      end
   end

   task automatic write_csr(logic [cdz_pkg::CSR_IDX_W-1:0] idx,
                            logic [cdz_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cdz_pkg::CSR_DEAD_ZONE) dz_reg = val[cdz_pkg::DZ_W-1:0];
      else gain_reg = val[cdz_pkg::GAIN_W-1:0];
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      while ((stick_queue.size() > 0 || pads_expected.size() > 0) && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 8000)) - 16'd4000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_burst(int count);
      repeat (count) stick_queue.push_back({rand_axis(), rand_axis()});
   endtask

   initial begin
      logic [15:0] corners[8];
      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                  16'h1999, 16'hE667, 16'h4000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 8; i++) stick_queue.push_back({corners[(i * 3) % 8], corners[i]});
      stick_queue.push_back({16'h5A82, 16'h5A82});
      stick_queue.push_back({16'hA57E, 16'h5A82});
      random_burst(190);
      drain();
      write_csr(cdz_pkg::CSR_DEAD_ZONE, 15'd0);
      write_csr(cdz_pkg::CSR_OUTPUT_GAIN, 15'd127);
      for (int i = 0; i < 8; i++) stick_queue.push_back({corners[i], corners[7 - i]});
      random_burst(110);
      drain();
      write_csr(cdz_pkg::CSR_DEAD_ZONE, 15'h7FFF);
      write_csr(cdz_pkg::CSR_OUTPUT_GAIN, 15'h7FFF);
      random_burst(50);
      drain();
      write_csr(cdz_pkg::CSR_DEAD_ZONE, 15'($urandom_range(0, 32767)));
      write_csr(cdz_pkg::CSR_OUTPUT_GAIN, 15'd0);
      random_burst(50);
      drain();
      write_csr(cdz_pkg::CSR_DEAD_ZONE, 15'($urandom_range(0, 16000)));
      write_csr(cdz_pkg::CSR_OUTPUT_GAIN, 15'($urandom_range(1, 127)));
      random_burst(100);
      drain();
      $display("Checked %0d words over five dead zone and gain settings,", n_checked);
      $display("including a long output stall and both saturation limits.");
      if (errors == 0 && pads_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cdz_pkg.sv
hw/rtl/cdz_div_pipe.sv
hw/rtl/circular_deadzone_stick_scaler.sv
test/tb_circular_deadzone_stick_scaler.sv
